// ===== rtl/psw_pkg.sv =====
// Shared types, constants and helpers for the particle step / wall bounce block.
// No dependencies; compiled first.
package psw_pkg;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int DT_W       = 24;
  localparam int DAMP_W     = 17;
  localparam int AREA_W     = 16;
  localparam int RAD_W      = 15;
  localparam int WALL_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIDE_W     = 64;

  // Default fraction bits of the Q formats
  localparam int FRAC_BITS_DEF = 16;

  // Product widths: signed data times unsigned factor (zero-extended)
  localparam int PROD_W  = DATA_W + DT_W + 1;
  localparam int DPROD_W = DATA_W + DAMP_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y     = 3'd6;

  // Register reset values
  localparam logic [DT_W-1:0]          RST_TIME_STEP   = 24'd1049;
  localparam logic [DAMP_W-1:0]        RST_DAMPING     = 17'd65535;
  localparam logic [AREA_W-1:0]        RST_AREA_WIDTH  = 16'd640;
  localparam logic [AREA_W-1:0]        RST_AREA_HEIGHT = 16'd480;
  localparam logic [RAD_W-1:0]         RST_RADIUS      = 15'd5;
  localparam logic signed [DATA_W-1:0] RST_ACCEL       = 32'sd0;

  // Wall codes
  localparam logic [WALL_W-1:0] HIT_NONE   = 3'd0;
  localparam logic [WALL_W-1:0] HIT_LEFT   = 3'd1;
  localparam logic [WALL_W-1:0] HIT_RIGHT  = 3'd2;
  localparam logic [WALL_W-1:0] HIT_TOP    = 3'd3;
  localparam logic [WALL_W-1:0] HIT_BOTTOM = 3'd4;

  // 32-bit signed limits at the wide width
  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = 64'shFFFF_FFFF_8000_0000;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DT_W-1:0]          dt;
    logic [DAMP_W-1:0]        damp;     // clamped to 1.0
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [WIDE_W-1:0] lo;       // radius bound
    logic signed [WIDE_W-1:0] hx;       // right bound
    logic signed [WIDE_W-1:0] hy;       // bottom bound
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic [WALL_W-1:0]        wall_hit;
  } out_item_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > S32_MAX_W) begin
      r = S32_MAX_W[DATA_W-1:0];
    end else if (x < S32_MIN_W) begin
      r = S32_MIN_W[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/psw_if.sv =====
// Valid/ready channel interfaces for particle items and result items.
// Depends on psw_pkg.
interface psw_in_if import psw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface psw_out_if import psw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_pos_x;
  logic signed [DATA_W-1:0] new_pos_y;
  logic signed [DATA_W-1:0] new_vel_x;
  logic signed [DATA_W-1:0] new_vel_y;
  logic [WALL_W-1:0]        wall_hit;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, wall_hit,
                  input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, wall_hit,
                  output ready);
endinterface

// ===== rtl/psw_cfg_regs.sv =====
// Configuration registers and derived wall bounds / clamped damping.
// Depends on psw_pkg.
module psw_cfg_regs import psw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [DT_W:0] ONE = (DT_W + 1)'(1) << FRAC_BITS;

  logic [DT_W-1:0]          time_step;
  logic [DAMP_W-1:0]        damping;
  logic [AREA_W-1:0]        area_width;
  logic [AREA_W-1:0]        area_height;
  logic [RAD_W-1:0]         radius;
  logic signed [DATA_W-1:0] accel_x;
  logic signed [DATA_W-1:0] accel_y;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= RST_TIME_STEP;
      damping     <= RST_DAMPING;
      area_width  <= RST_AREA_WIDTH;
      area_height <= RST_AREA_HEIGHT;
      radius      <= RST_RADIUS;
      accel_x     <= RST_ACCEL;
      accel_y     <= RST_ACCEL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:   time_step   <= cfg_data[DT_W-1:0];
        REG_DAMPING:     damping     <= cfg_data[DAMP_W-1:0];
        REG_AREA_WIDTH:  area_width  <= cfg_data[AREA_W-1:0];
        REG_AREA_HEIGHT: area_height <= cfg_data[AREA_W-1:0];
        REG_RADIUS:      radius      <= cfg_data[RAD_W-1:0];
        REG_ACCEL_X:     accel_x     <= cfg_data;
        REG_ACCEL_Y:     accel_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derived values: damping above 1.0 is clamped, bounds in Q format
  always_comb begin
    cfg.dt      = time_step;
    cfg.accel_x = accel_x;
    cfg.accel_y = accel_y;
    if ((DT_W + 1)'(damping) > ONE) begin
      cfg.damp = ONE[DAMP_W-1:0];
    end else begin
      cfg.damp = damping;
    end
    cfg.lo = WIDE_W'(radius) <<< FRAC_BITS;
    cfg.hx = (WIDE_W'(area_width) - WIDE_W'(radius)) <<< FRAC_BITS;
    cfg.hy = (WIDE_W'(area_height) - WIDE_W'(radius)) <<< FRAC_BITS;
  end

endmodule

// ===== rtl/psw_axis.sv =====
// One axis of the integrator: four register stages from (p, v) to (p1, v2).
// Depends on psw_pkg.
module psw_axis import psw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] pos,
  input  logic signed [DATA_W-1:0] vel,
  input  logic signed [DATA_W-1:0] accel,
  input  logic [DT_W-1:0]          dt,
  input  logic [DAMP_W-1:0]        damp,
  output logic signed [DATA_W-1:0] pos_out,
  output logic signed [DATA_W-1:0] vel_out
);

  localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0]  acc_prod;
  logic signed [DATA_W-1:0]  pos_s1, vel_s1;
  logic signed [DATA_W-1:0]  pos_s2, vel_s2;
  logic signed [PROD_W-1:0]  pos_prod;
  logic signed [DPROD_W-1:0] damp_prod;
  logic signed [DATA_W-1:0]  pos_s3;
  logic signed [WIDE_W-1:0]  acc_w, vel_sum, pos_w, pos_sum, damp_w;

  // Stage 1: a * dt
  always_ff @(posedge clk) begin
    if (en) begin
      acc_prod <= accel * $signed({1'b0, dt});
      pos_s1   <= pos;
      vel_s1   <= vel;
    end
  end

  // Stage 2: v1 = sat(v + rnd(a * dt))
  always_comb begin
    acc_w   = WIDE_W'(acc_prod) + HALF;
    vel_sum = WIDE_W'(vel_s1) + (acc_w >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vel_s2 <= sat32(vel_sum);
      pos_s2 <= pos_s1;
    end
  end

  // Stage 3: v1 * dt and v1 * damping
  always_ff @(posedge clk) begin
    if (en) begin
      pos_prod  <= vel_s2 * $signed({1'b0, dt});
      damp_prod <= vel_s2 * $signed({1'b0, damp});
      pos_s3    <= pos_s2;
    end
  end

  // Stage 4: p1 = sat(p + rnd(v1 * dt)), v2 = sat(rnd(v1 * damping))
  always_comb begin
    pos_w   = WIDE_W'(pos_prod) + HALF;
    pos_sum = WIDE_W'(pos_s3) + (pos_w >>> FRAC_BITS);
    damp_w  = WIDE_W'(damp_prod) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_out <= sat32(pos_sum);
      vel_out <= sat32(damp_w >>> FRAC_BITS);
    end
  end

endmodule

// ===== rtl/psw_wall.sv =====
// Wall check and reflection stage; drives the output register.
// Depends on psw_pkg.
module psw_wall import psw_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  cfg_t                     cfg,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] vel_x,
  input  logic signed [DATA_W-1:0] vel_y,
  output out_item_t                res
);

  logic signed [WIDE_W-1:0] px_w, py_w, vx_w, vy_w;
  logic signed [DATA_W-1:0] mir_lx, mir_rx, mir_ty, mir_by, neg_vx, neg_vy;
  out_item_t                res_next;

  // Candidate mirrors and negations, then priority select
  always_comb begin
    px_w   = WIDE_W'(pos_x);
    py_w   = WIDE_W'(pos_y);
    vx_w   = WIDE_W'(vel_x);
    vy_w   = WIDE_W'(vel_y);
    mir_lx = sat32((cfg.lo <<< 1) - px_w);
    mir_rx = sat32((cfg.hx <<< 1) - px_w);
    mir_ty = sat32((cfg.lo <<< 1) - py_w);
    mir_by = sat32((cfg.hy <<< 1) - py_w);
    neg_vx = sat32(-vx_w);
    neg_vy = sat32(-vy_w);

    res_next.new_pos_x = pos_x;
    res_next.new_pos_y = pos_y;
    res_next.new_vel_x = vel_x;
    res_next.new_vel_y = vel_y;
    res_next.wall_hit  = HIT_NONE;
    if (px_w < cfg.lo && vel_x < 0) begin
      res_next.new_pos_x = mir_lx;
      res_next.new_vel_x = neg_vx;
      res_next.wall_hit  = HIT_LEFT;
    end else if (px_w > cfg.hx && vel_x > 0) begin
      res_next.new_pos_x = mir_rx;
      res_next.new_vel_x = neg_vx;
      res_next.wall_hit  = HIT_RIGHT;
    end else if (py_w < cfg.lo && vel_y < 0) begin
      res_next.new_pos_y = mir_ty;
      res_next.new_vel_y = neg_vy;
      res_next.wall_hit  = HIT_TOP;
    end else if (py_w > cfg.hy && vel_y > 0) begin
      res_next.new_pos_y = mir_by;
      res_next.new_vel_y = neg_vy;
      res_next.wall_hit  = HIT_BOTTOM;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/particle_step_wall_bounce.sv =====
// Particle step with wall bounce: top level.
// Depends on psw_pkg, psw_if, psw_cfg_regs, psw_axis, psw_wall.
//
// Usage:
//   item_in carries one particle (pos_x, pos_y, vel_x, vel_y, signed Q16.16);
//   item_out returns one result per particle (new position, new velocity,
//   wall_hit code), in the order the particles came in.
//   Items move on valid && ready. Configuration is written through cfg_we,
//   cfg_index, cfg_data, only while no items are in flight; the user must
//   keep to this, the block itself has no check for it.
// Pipeline: four integrator stages, then the wall stage's output register.
// Throughput: one item per cycle while item_out is not held; the stage depth
//   is set by the 32x24 a*dt, v1*dt and 32x17 v1*damping multipliers.
// Reset: all pipeline valid bits clear, the registers take their defaults
//   (dt 1049, damping 65535, area 640x480, radius 5, no acceleration).
// Stall: when item_out is held, the whole pipeline freezes and item_in.ready
//   drops; while the output register is empty, bubbles are still absorbed.
module particle_step_wall_bounce import psw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  psw_in_if.sink                item_in,
  psw_out_if.source             item_out
);

  localparam int DEPTH = 5;

  cfg_t                     cfg;
  logic                     en;
  logic [DEPTH-1:0]         vld;
  logic signed [DATA_W-1:0] p1x, p1y, v2x, v2y;
  out_item_t                res;

  // Pipeline advances unless a result is waiting and item_out.ready is low
  assign en            = !vld[DEPTH-1] || item_out.ready;
  assign item_in.ready = en;

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], item_in.valid};
    end
  end

  psw_cfg_regs #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk     (clk),
    .en      (en),
    .pos     (item_in.pos_x),
    .vel     (item_in.vel_x),
    .accel   (cfg.accel_x),
    .dt      (cfg.dt),
    .damp    (cfg.damp),
    .pos_out (p1x),
    .vel_out (v2x)
  );

  psw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk     (clk),
    .en      (en),
    .pos     (item_in.pos_y),
    .vel     (item_in.vel_y),
    .accel   (cfg.accel_y),
    .dt      (cfg.dt),
    .damp    (cfg.damp),
    .pos_out (p1y),
    .vel_out (v2y)
  );

  psw_wall u_wall (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .pos_x (p1x),
    .pos_y (p1y),
    .vel_x (v2x),
    .vel_y (v2y),
    .res   (res)
  );

  // Result channel
  assign item_out.valid     = vld[DEPTH-1];
  assign item_out.new_pos_x = res.new_pos_x;
  assign item_out.new_pos_y = res.new_pos_y;
  assign item_out.new_vel_x = res.new_vel_x;
  assign item_out.new_vel_y = res.new_vel_y;
  assign item_out.wall_hit  = res.wall_hit;

endmodule

// ===== rtl/psw_checker.sv =====
// Port-level checks for particle_step_wall_bounce, attached by bind.
// Depends on psw_pkg and the top level.
module psw_checker import psw_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] new_pos_x,
  input logic signed [DATA_W-1:0] new_vel_x,
  input logic signed [DATA_W-1:0] new_vel_y,
  input logic [WALL_W-1:0]        wall_hit
);

  // Stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_pos_x) && $stable(wall_hit))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Only one of the defined wall codes
  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> wall_hit <= HIT_BOTTOM)
    else $error("undefined wall code");

  // Left or top bounce sends the particle inward (positive velocity)
  a_lo_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wall_hit == HIT_LEFT || wall_hit == HIT_TOP) |->
      (wall_hit == HIT_LEFT ? new_vel_x > 0 : new_vel_y > 0))
    else $error("left/top bounce with wrong velocity sign");

  // Right or bottom bounce sends the particle inward (negative velocity)
  a_hi_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wall_hit == HIT_RIGHT || wall_hit == HIT_BOTTOM) |->
      (wall_hit == HIT_RIGHT ? new_vel_x < 0 : new_vel_y < 0))
    else $error("right/bottom bounce with wrong velocity sign");

endmodule

bind particle_step_wall_bounce psw_checker u_psw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (item_out.valid),
  .out_ready (item_out.ready),
  .new_pos_x (item_out.new_pos_x),
  .new_vel_x (item_out.new_vel_x),
  .new_vel_y (item_out.new_vel_y),
  .wall_hit  (item_out.wall_hit)
);

// ===== dv/particle_step_wall_bounce_test.sv =====
// Testbench for particle_step_wall_bounce: directed table then random particles,
// every result checked against a table value or an in-bench step predictor.
// Depends on psw_pkg, psw_if and the RTL of particle_step_wall_bounce.
module particle_step_wall_bounce_test;
  import psw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     LATENCY     = 5;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     NUM_PHASES  = 8;
  localparam int     PHASE_ITEMS = 190;
  localparam int     MAX_PRINTS  = 40;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -Q_MAX - 64'sd1;

  localparam logic [DAMP_W-1:0]    DAMP_ONE  = 1 << FRAC;
  // index 7 is not a register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
  } particle_t;

  typedef struct {
    int        tag;
    out_item_t res;
  } move_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICTED, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    particle_t               p;
    out_item_t               want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  psw_in_if  particles_in ();
  psw_out_if particles_out ();

  // Register mirror used by the predictor
  logic [DT_W-1:0]          m_dt;
  logic [DAMP_W-1:0]        m_damp;
  logic [AREA_W-1:0]        m_width;
  logic [AREA_W-1:0]        m_height;
  logic [RAD_W-1:0]         m_radius;
  logic signed [DATA_W-1:0] m_ax;
  logic signed [DATA_W-1:0] m_ay;

  move_t predicted_moves [$];
  bit    steady = 1'b0;
  int    errors = 0;
  int    items_sent = 0;
  int    directed_items = 0;
  int    settings_used = 1;
  int    cycle_count = 0;
  int    hit_count [8];

  particle_step_wall_bounce #(
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_in   (particles_in),
    .item_out  (particles_out)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_moves.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Round to nearest (ties up) and drop the fraction bits
  function automatic longint round_q(longint x);
    return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_q(longint x);
    if (x > Q_MAX) return Q_MAX[DATA_W-1:0];
    if (x < Q_MIN) return Q_MIN[DATA_W-1:0];
    return x[DATA_W-1:0];
  endfunction

  // One integration step plus at most one wall reflection
  function automatic out_item_t advance_particle(particle_t p);
    longint    vx, vy, px, py, dtl, dmp, lo, hx, hy;
    out_item_t r;
    dtl = longint'(m_dt);
    dmp = (m_damp > DAMP_ONE) ? longint'(DAMP_ONE) : longint'(m_damp);

    vx = clamp_q(longint'(p.vel_x) + round_q(longint'(m_ax) * dtl));
    vy = clamp_q(longint'(p.vel_y) + round_q(longint'(m_ay) * dtl));
    px = clamp_q(longint'(p.pos_x) + round_q(vx * dtl));
    py = clamp_q(longint'(p.pos_y) + round_q(vy * dtl));
    vx = clamp_q(round_q(vx * dmp));
    vy = clamp_q(round_q(vy * dmp));

    lo = longint'(m_radius) <<< FRAC;
    hx = (longint'(m_width) - longint'(m_radius)) <<< FRAC;
    hy = (longint'(m_height) - longint'(m_radius)) <<< FRAC;

    // priority: left, right, top, bottom; outward motion only
    r.wall_hit = HIT_NONE;
    if (px < lo && vx < 0) begin
      px = clamp_q(2 * lo - px);
      vx = clamp_q(-vx);
      r.wall_hit = HIT_LEFT;
    end else if (px > hx && vx > 0) begin
      px = clamp_q(2 * hx - px);
      vx = clamp_q(-vx);
      r.wall_hit = HIT_RIGHT;
    end else if (py < lo && vy < 0) begin
      py = clamp_q(2 * lo - py);
      vy = clamp_q(-vy);
      r.wall_hit = HIT_TOP;
    end else if (py > hy && vy > 0) begin
      py = clamp_q(2 * hy - py);
      vy = clamp_q(-vy);
      r.wall_hit = HIT_BOTTOM;
    end
    r.new_pos_x = px[DATA_W-1:0];
    r.new_pos_y = py[DATA_W-1:0];
    r.new_vel_x = vx[DATA_W-1:0];
    r.new_vel_y = vy[DATA_W-1:0];
    return r;
  endfunction

  // Directed table rows
  function automatic row_t set_reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = d;
    return r;
  endfunction

  function automatic row_t predicted_row(logic signed [DATA_W-1:0] px, py, vx, vy);
    row_t r;
    r = '0;
    r.kind = ROW_PREDICTED;
    r.p    = '{px, py, vx, vy};
    return r;
  endfunction

  function automatic row_t known_row(logic signed [DATA_W-1:0] px, py, vx, vy,
                                     logic signed [DATA_W-1:0] npx, npy, nvx, nvy,
                                     logic [WALL_W-1:0] hit);
    row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.p    = '{px, py, vx, vy};
    r.want = '{npx, npy, nvx, nvy, hit};
    return r;
  endfunction

  // Random bits above the register width, low bits carry the value
  function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = (32'd1 << w) - 32'd1;
    return ($urandom & ~keep) | (v & keep);
  endfunction

  // Coordinate near a wall, anywhere inside, or raw
  function automatic logic signed [DATA_W-1:0] pick_coord(longint span);
    longint lo, hi, c;
    lo = longint'(m_radius) <<< FRAC;
    hi = (span - longint'(m_radius)) <<< FRAC;
    case ($urandom_range(0, 3))
      0:       c = lo + longint'($urandom_range(0, 8 << FRAC)) - (longint'(4) <<< FRAC);
      1:       c = hi + longint'($urandom_range(0, 8 << FRAC)) - (longint'(4) <<< FRAC);
      2:       c = (longint'($urandom_range(0, int'(span))) <<< FRAC)
                   + longint'($urandom_range(0, 65535));
      default: c = longint'($urandom);
    endcase
    return c[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_speed();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(0, 1 << 23) - (1 << 22);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_accel();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom_range(0, 1 << 23) - (1 << 22);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH %s", msg);
  endtask

  // Register write, mirrored into the predictor's copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    case (idx)
      REG_TIME_STEP:   m_dt     = d[DT_W-1:0];
      REG_DAMPING:     m_damp   = d[DAMP_W-1:0];
      REG_AREA_WIDTH:  m_width  = d[AREA_W-1:0];
      REG_AREA_HEIGHT: m_height = d[AREA_W-1:0];
      REG_RADIUS:      m_radius = d[RAD_W-1:0];
      REG_ACCEL_X:     m_ax     = d;
      REG_ACCEL_Y:     m_ay     = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Every item yields one result, so an empty queue means the block is idle
  task automatic drain_pipeline();
    particles_in.valid = 1'b0;
    while (predicted_moves.size() != 0) @(negedge clk);
  endtask

  task automatic send_particle(particle_t p, bit known, out_item_t want);
    move_t m;
    while (!steady && $urandom_range(0, 99) < 14) begin
      particles_in.valid = 1'b0;
      @(negedge clk);
    end
    particles_in.valid = 1'b1;
    particles_in.pos_x = p.pos_x;
    particles_in.pos_y = p.pos_y;
    particles_in.vel_x = p.vel_x;
    particles_in.vel_y = p.vel_y;
    do @(posedge clk); while (!particles_in.ready);
    m.tag = items_sent;
    m.res = known ? want : advance_particle(p);
    predicted_moves.push_back(m);
    items_sent++;
    @(negedge clk);
  endtask

  // New random setting; extremes come up now and then
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 24'hFF_FFFF;
      2, 3:    v = 1049;
      default: v = $urandom_range(1, 1 << 18);
    endcase
    write_reg(REG_TIME_STEP, with_noise(v, DT_W));
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1 << FRAC;
      2:       v = $urandom_range((1 << FRAC) + 1, (1 << DAMP_W) - 1);
      3:       v = 65535;
      default: v = $urandom_range(60000, 1 << FRAC);
    endcase
    write_reg(REG_DAMPING, with_noise(v, DAMP_W));
    case ($urandom_range(0, 7))
      0:       v = 1;
      1:       v = 65535;
      default: v = $urandom_range(50, 2000);
    endcase
    write_reg(REG_AREA_WIDTH, with_noise(v, AREA_W));
    case ($urandom_range(0, 7))
      0:       v = 1;
      1:       v = 65535;
      default: v = $urandom_range(50, 2000);
    endcase
    write_reg(REG_AREA_HEIGHT, with_noise(v, AREA_W));
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 32767;
      default: v = $urandom_range(0, 20);
    endcase
    write_reg(REG_RADIUS, with_noise(v, RAD_W));
    write_reg(REG_ACCEL_X, pick_accel());
    write_reg(REG_ACCEL_Y, pick_accel());
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    settings_used++;
  endtask

  // Result sink: ready drops about 14% of cycles unless in a steady stretch
  initial begin
    particles_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      particles_out.ready = steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // Result checker
  always @(posedge clk) begin : check_results
    out_item_t got;
    move_t     head;
    if (!rst && particles_out.valid && particles_out.ready) begin
      got.new_pos_x = particles_out.new_pos_x;
      got.new_pos_y = particles_out.new_pos_y;
      got.new_vel_x = particles_out.new_vel_x;
      got.new_vel_y = particles_out.new_vel_y;
      got.wall_hit  = particles_out.wall_hit;
      if (predicted_moves.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos (%0d,%0d) wall %0d",
                                  got.new_pos_x, got.new_pos_y, got.wall_hit));
      end else begin
        head = predicted_moves.pop_front();
        hit_count[got.wall_hit]++;
        if (got.new_pos_x !== head.res.new_pos_x)
          report_mismatch($sformatf("item %0d new_pos_x got %0d want %0d", head.tag,
                                    got.new_pos_x, head.res.new_pos_x));
        if (got.new_pos_y !== head.res.new_pos_y)
          report_mismatch($sformatf("item %0d new_pos_y got %0d want %0d", head.tag,
                                    got.new_pos_y, head.res.new_pos_y));
        if (got.new_vel_x !== head.res.new_vel_x)
          report_mismatch($sformatf("item %0d new_vel_x got %0d want %0d", head.tag,
                                    got.new_vel_x, head.res.new_vel_x));
        if (got.new_vel_y !== head.res.new_vel_y)
          report_mismatch($sformatf("item %0d new_vel_y got %0d want %0d", head.tag,
                                    got.new_vel_y, head.res.new_vel_y));
        if (got.wall_hit !== head.res.wall_hit)
          report_mismatch($sformatf("item %0d wall_hit got %0d want %0d", head.tag,
                                    got.wall_hit, head.res.wall_hit));
      end
    end
  end

  // Stimulus
  initial begin
    row_t steps [$];
    particle_t p;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    particles_in.valid = 1'b0;
    particles_in.pos_x = '0;
    particles_in.pos_y = '0;
    particles_in.vel_x = '0;
    particles_in.vel_y = '0;
    m_dt     = RST_TIME_STEP;
    m_damp   = RST_DAMPING;
    m_width  = RST_AREA_WIDTH;
    m_height = RST_AREA_HEIGHT;
    m_radius = RST_RADIUS;
    m_ax     = RST_ACCEL;
    m_ay     = RST_ACCEL;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    steps = '{
      // reset defaults: at rest and at the range limits nothing moves
      known_row(0, 0, 0, 0, 0, 0, 0, 0, HIT_NONE),
      known_row(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, HIT_NONE),
      known_row(32'h8000_0000, 32'h8000_0000, 0, 0,
                32'h8000_0000, 32'h8000_0000, 0, 0, HIT_NONE),
      // one bounce per wall
      predicted_row(2 << 16, 100 << 16, -(10 << 16), 0),
      predicted_row(639 << 16, 100 << 16, 10 << 16, 0),
      predicted_row(100 << 16, 1 << 16, 0, -(5 << 16)),
      predicted_row(100 << 16, 479 << 16, 0, 5 << 16),
      // two walls crossed at once: left wins, then right over bottom and over top
      predicted_row(0, 0, -(1 << 16), -(1 << 16)),
      predicted_row(700 << 16, 500 << 16, 1 << 16, 1 << 16),
      predicted_row(320 << 16, 240 << 16, 32'h7FFF_FFFF, 32'h8000_0000),
      // write to the spare index must change nothing
      set_reg_row(REG_SPARE, 32'hFFFF_FFFF),
      predicted_row(4 << 16, 476 << 16, -(3 << 16), 3 << 16),
      // damping of exactly one: most negative velocity negates to the max
      set_reg_row(REG_DAMPING, 1 << FRAC),
      predicted_row(0, 240 << 16, 32'h8000_0000, 0),
      // damping above one is clamped
      set_reg_row(REG_DAMPING, 32'hFFFF_FFFF),
      predicted_row(10 << 16, 10 << 16, 12345, -54321),
      // full damping kills the velocity, so no wall fires
      set_reg_row(REG_DAMPING, 0),
      predicted_row(0, 0, -(1 << 16), -(1 << 16)),
      // largest step with full accelerations saturates every sum
      set_reg_row(REG_TIME_STEP, 32'hFFFF_FFFF),
      set_reg_row(REG_ACCEL_X, 32'h7FFF_FFFF),
      set_reg_row(REG_ACCEL_Y, 32'h8000_0000),
      set_reg_row(REG_DAMPING, 65535),
      predicted_row(0, 0, 32'h7FFF_FFFF, 32'h8000_0000),
      predicted_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
      // radius larger than the area: bounds cross and mirrors saturate
      set_reg_row(REG_TIME_STEP, 1049),
      set_reg_row(REG_ACCEL_X, 0),
      set_reg_row(REG_ACCEL_Y, 0),
      set_reg_row(REG_RADIUS, 32767),
      set_reg_row(REG_AREA_WIDTH, 1),
      set_reg_row(REG_AREA_HEIGHT, 1),
      predicted_row(32'h8000_0000, 0, -(1 << 16), 0),
      predicted_row(32'h7FFF_FFFF, 0, 1 << 16, 0),
      // zero radius, widest area, zero step
      set_reg_row(REG_RADIUS, 0),
      set_reg_row(REG_AREA_WIDTH, 65535),
      set_reg_row(REG_AREA_HEIGHT, 65535),
      set_reg_row(REG_TIME_STEP, 0),
      predicted_row(-1, -1, -(1 << 16), 5 << 16),
      predicted_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF)
    };

    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_WRITE: begin
          drain_pipeline();
          write_reg(steps[i].idx, steps[i].data);
        end
        ROW_KNOWN: send_particle(steps[i].p, 1'b1, steps[i].want);
        default:   send_particle(steps[i].p, 1'b0, '0);
      endcase
    end
    directed_items = items_sent;

    // Random phases: a nominal setting with gravity first, then random ones
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipeline();
      if (ph == 0) begin
        write_reg(REG_TIME_STEP, with_noise(1049, DT_W));
        write_reg(REG_DAMPING, with_noise(65535, DAMP_W));
        write_reg(REG_AREA_WIDTH, with_noise(640, AREA_W));
        write_reg(REG_AREA_HEIGHT, with_noise(480, AREA_W));
        write_reg(REG_RADIUS, with_noise(5, RAD_W));
        write_reg(REG_ACCEL_X, 0);
        write_reg(REG_ACCEL_Y, 642253);
        settings_used++;
      end else begin
        pick_setting();
      end
      steady = (ph == 3);
      repeat (PHASE_ITEMS) begin
        p.pos_x = pick_coord(longint'(m_width));
        p.pos_y = pick_coord(longint'(m_height));
        p.vel_x = pick_speed();
        p.vel_y = pick_speed();
        send_particle(p, 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_pipeline();
    repeat (4 * LATENCY) @(posedge clk);

    $display("Ran %0d particles (%0d directed) over %0d register settings, %0d cycles.",
             items_sent, directed_items, settings_used, cycle_count);
    $display("Bounces seen: left %0d right %0d top %0d bottom %0d, none %0d.",
             hit_count[HIT_LEFT], hit_count[HIT_RIGHT], hit_count[HIT_TOP],
             hit_count[HIT_BOTTOM], hit_count[HIT_NONE]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
